/* sv/positional_list_store_unit_assert.svh */
// Assertion macros used by the list store RTL.
// PLSU_ASSERT is quiet while reset is high; PLSU_ASSERT_ALWAYS checks on every edge.
`ifndef POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PLSU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PLSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLSU_ASSERT(lbl, clk, rst, prop, msg)
`define PLSU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/plsu_pkg.sv */
package plsu_pkg;

   // Default list depth
   localparam int CAPACITY_DEF = 32;

   // Field widths on the ports
   localparam int KIND_W     = 3;
   localparam int POS_W      = 6;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int INDEX_W    = 5;
   localparam int COUNT_W    = 6;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR  = 3'd0,
      KIND_INSERT = 3'd1,
      KIND_DELETE = 3'd2,
      KIND_SEARCH = 3'd3,
      KIND_READ   = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_RESOLVE
   } fsm_type;

   // Command broadcast from the controller to every cell
   typedef struct packed {
      logic                      ins_en;
      logic                      del_en;
      logic                      search_en;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

/* sv/plsu_cell.sv */
module plsu_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 6
) (
   input  logic                                clock,
   input  plsu_pkg::cell_ctrl_type             ctrl,
   input  logic [CNT_W-1:0]                    count,
   input  logic signed [plsu_pkg::VALUE_W-1:0] left_entry,
   input  logic signed [plsu_pkg::VALUE_W-1:0] right_entry,
   output logic signed [plsu_pkg::VALUE_W-1:0] entry,
   output logic                                match,
   output logic                                sel
);

   logic signed [plsu_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic                                match_ff, match_in;
   logic                                sel_ff, sel_in;
   logic                                occupied;

   assign occupied = INDEX < int'(count);

   // Shift up on insert, down on delete, otherwise hold
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en) begin
         if (INDEX > int'(ctrl.position)) begin
            entry_in = left_entry;
         end else if (INDEX == int'(ctrl.position)) begin
            entry_in = ctrl.value;
         end
      end else if (ctrl.del_en) begin
         if (INDEX >= int'(ctrl.position)) begin
            entry_in = right_entry;
         end
      end
   end

   // Local compare and position decode
   assign match_in = ctrl.search_en && occupied && (entry_ff == ctrl.value);
   assign sel_in   = (INDEX == int'(ctrl.position));

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
      sel_ff   <= sel_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;
   assign sel   = sel_ff;

endmodule

/* sv/plsu_resolve.sv */
module plsu_resolve #(
   parameter int CAPACITY = plsu_pkg::CAPACITY_DEF,
   parameter int IDX_W    = 5
) (
   input  logic [CAPACITY-1:0]                 match_vec,
   input  logic [CAPACITY-1:0]                 sel_vec,
   input  logic signed [plsu_pkg::VALUE_W-1:0] entry_vec [CAPACITY],
   output logic                                any_match,
   output logic [IDX_W-1:0]                    match_index,
   output logic signed [plsu_pkg::VALUE_W-1:0] sel_data
);

   // Lowest matching cell wins
   always_comb begin
      any_match   = |match_vec;
      match_index = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            match_index = IDX_W'(i);
         end
      end
   end

   // One-hot select of the addressed cell
   always_comb begin
      sel_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (sel_vec[i]) begin
            sel_data = sel_data | entry_vec[i];
         end
      end
   end

endmodule

/* sv/positional_list_store_unit.sv */
// Ordered list of signed 32-bit entries held in a row of CAPACITY cells, one entry per
// cell. Each request item carries a kind (clear, insert, delete, search, read), a
// position and a value; each gives exactly one response item with status, found index,
// read value and the count after the operation. An item goes from accept to a registered
// response in steps: it is captured, then every cell shifts toward or away from its
// neighbor and compares its entry against the search value, then the match and select
// bits from the cells are reduced to an index and a read word. The next item is taken
// in the cycle after the response is loaded, so a new item is not accepted before the
// last one is through; a held response stalls only the final reduction step. Entries
// beyond the count are never reported, so the cells need no clearing after reset.
`include "positional_list_store_unit_assert.svh"

module positional_list_store_unit #(
   parameter int CAPACITY = plsu_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // position [5:0], value [37:6], zero [39:38]
   input  logic [plsu_pkg::REQ_DATA_W-1:0]     req_tdata,
   // kind [2:0]
   input  logic [plsu_pkg::KIND_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // found_index [4:0], read_value [36:5], count [42:37], zero [47:43]
   output logic [plsu_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status [1:0]
   output logic [plsu_pkg::STATUS_W-1:0]       rsp_tuser
);

   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int POS_W   = plsu_pkg::POS_W;
   localparam int VALUE_W = plsu_pkg::VALUE_W;
   localparam int INDEX_W = plsu_pkg::INDEX_W;
   localparam int COUNT_W = plsu_pkg::COUNT_W;
   localparam int RSP_W   = plsu_pkg::RSP_DATA_W;
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int PAD_W   = RSP_W - (INDEX_W + VALUE_W + COUNT_W);

   plsu_pkg::fsm_type       fsm_ff, fsm_in;
   plsu_pkg::kind_type      kind_ff;
   logic [POS_W-1:0]        pos_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   plsu_pkg::status_type    op_status_ff, op_status_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   plsu_pkg::status_type    status_ff, status_in;
   logic [INDEX_W-1:0]      found_ff, found_in;
   logic signed [VALUE_W-1:0] read_ff, read_in;
   logic [COUNT_W-1:0]      rcount_ff, rcount_in;

   logic                    req_accept;
   logic                    rsp_load;
   logic                    ins_ok;
   logic                    rng_ok;
   logic [CMP_W-1:0]        pos_ext;
   logic [CMP_W-1:0]        cnt_ext;
   plsu_pkg::cell_ctrl_type ctrl;

   logic signed [VALUE_W-1:0] entry_w [CAPACITY];
   logic [CAPACITY-1:0]       match_w;
   logic [CAPACITY-1:0]       sel_w;
   logic                      any_match;
   logic [IDX_W-1:0]          match_index;
   logic signed [VALUE_W-1:0] sel_data;

   assign req_tready = (fsm_ff == plsu_pkg::FSM_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_load   = (fsm_ff == plsu_pkg::FSM_RESOLVE) && (!rsp_tvalid_ff || rsp_tready);

   // Capture the request item
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff  <= plsu_pkg::kind_type'(req_tuser);
         pos_ff   <= req_tdata[POS_W-1:0];
         value_ff <= req_tdata[POS_W+VALUE_W-1:POS_W];
      end
   end

   // Range checks against the current count
   assign pos_ext = CMP_W'(pos_ff);
   assign cnt_ext = CMP_W'(count_ff);
   assign ins_ok  = (pos_ext <= cnt_ext) && (cnt_ext < CMP_W'(CAPACITY));
   assign rng_ok  = (pos_ext < cnt_ext);

   // Cell command
   always_comb begin
      ctrl           = '0;
      ctrl.position  = pos_ff;
      ctrl.value     = value_ff;
      ctrl.search_en = (kind_ff == plsu_pkg::KIND_SEARCH);
      if (fsm_ff == plsu_pkg::FSM_EXEC) begin
         ctrl.ins_en = (kind_ff == plsu_pkg::KIND_INSERT) && ins_ok;
         ctrl.del_en = (kind_ff == plsu_pkg::KIND_DELETE) && rng_ok;
      end
   end

   // Sequencer: capture, execute in the cells, reduce into the response register
   always_comb begin
      fsm_in       = fsm_ff;
      count_in     = count_ff;
      op_status_in = op_status_ff;
      case (fsm_ff)
         plsu_pkg::FSM_IDLE: begin
            if (req_accept) begin
               fsm_in = plsu_pkg::FSM_EXEC;
            end
         end
         plsu_pkg::FSM_EXEC: begin
            fsm_in       = plsu_pkg::FSM_RESOLVE;
            op_status_in = plsu_pkg::ST_OK;
            case (kind_ff)
               plsu_pkg::KIND_CLEAR: begin
                  count_in = '0;
               end
               plsu_pkg::KIND_INSERT: begin
                  if (ins_ok) begin
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     op_status_in = plsu_pkg::ST_INVALID;
                  end
               end
               plsu_pkg::KIND_DELETE: begin
                  if (rng_ok) begin
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     op_status_in = plsu_pkg::ST_INVALID;
                  end
               end
               plsu_pkg::KIND_SEARCH: begin
                  op_status_in = plsu_pkg::ST_OK;
               end
               plsu_pkg::KIND_READ: begin
                  if (!rng_ok) begin
                     op_status_in = plsu_pkg::ST_INVALID;
                  end
               end
               default: begin
                  op_status_in = plsu_pkg::ST_INVALID;
               end
            endcase
         end
         plsu_pkg::FSM_RESOLVE: begin
            if (rsp_load) begin
               fsm_in = plsu_pkg::FSM_IDLE;
            end
         end
         default: begin
            fsm_in = plsu_pkg::FSM_IDLE;
         end
      endcase
   end

   // Response register: load on resolve, drop when taken
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      read_in       = read_ff;
      rcount_in     = rcount_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         status_in     = op_status_ff;
         found_in      = '0;
         read_in       = '0;
         rcount_in     = COUNT_W'(count_ff);
         if (kind_ff == plsu_pkg::KIND_SEARCH) begin
            if (any_match) begin
               status_in = plsu_pkg::ST_OK;
               found_in  = INDEX_W'(match_index);
            end else begin
               status_in = plsu_pkg::ST_NOT_FOUND;
            end
         end
         if ((kind_ff == plsu_pkg::KIND_READ) && (op_status_ff == plsu_pkg::ST_OK)) begin
            read_in = sel_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= plsu_pkg::FSM_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         fsm_ff        <= fsm_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_status_ff <= op_status_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      read_ff      <= read_in;
      rcount_ff    <= rcount_in;
   end

   // Row of cells; each end sees zero beyond the row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_w;
      logic signed [VALUE_W-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_left
         assign left_w = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_right
         assign right_w = entry_w[i+1];
      end
      plsu_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .left_entry  (left_w),
         .right_entry (right_w),
         .entry       (entry_w[i]),
         .match       (match_w[i]),
         .sel         (sel_w[i])
      );
   end

   plsu_resolve #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_resolve (
      .match_vec   (match_w),
      .sel_vec     (sel_w),
      .entry_vec   (entry_w),
      .any_match   (any_match),
      .match_index (match_index),
      .sel_data    (sel_data)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rcount_ff, read_ff, found_ff};

   `PLSU_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `PLSU_ASSERT(a_accept_exec, clock, reset, req_accept |=> fsm_ff == plsu_pkg::FSM_EXEC, "accepted item did not execute")
   `PLSU_ASSERT(a_rsp_from_resolve, clock, reset, $rose(rsp_tvalid_ff) |-> $past(fsm_ff == plsu_pkg::FSM_RESOLVE), "response without resolve")
   `PLSU_ASSERT(a_sel_onehot, clock, reset, (fsm_ff == plsu_pkg::FSM_RESOLVE) |-> $onehot0(sel_w), "several cells selected")
   `PLSU_ASSERT(a_insert_count, clock, reset, ((fsm_ff == plsu_pkg::FSM_RESOLVE) && $past(fsm_ff == plsu_pkg::FSM_EXEC) && (kind_ff == plsu_pkg::KIND_INSERT) && (op_status_ff == plsu_pkg::ST_OK)) |-> (count_ff == $past(count_ff) + CNT_W'(1)), "insert did not grow count")
   `PLSU_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> (!rsp_tvalid_ff && (fsm_ff == plsu_pkg::FSM_IDLE)), "not idle after reset")

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 12;

   localparam int CAPACITY_DEF = plsu_pkg::CAPACITY_DEF;
   localparam int KIND_W       = plsu_pkg::KIND_W;
   localparam int POS_W        = plsu_pkg::POS_W;
   localparam int VALUE_W      = plsu_pkg::VALUE_W;
   localparam int STATUS_W     = plsu_pkg::STATUS_W;
   localparam int INDEX_W      = plsu_pkg::INDEX_W;
   localparam int COUNT_W      = plsu_pkg::COUNT_W;
   localparam int REQ_DATA_W   = plsu_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W   = plsu_pkg::RSP_DATA_W;

   // traffic shapes for the random part
   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   typedef struct packed {
      plsu_pkg::status_type      status;
      logic [INDEX_W-1:0]        found_index;
      logic signed [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0]        count;
   } list_outcome_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [KIND_W-1:0]       req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0]     rsp_tuser;

   // shadow copy of the list
   logic signed [VALUE_W-1:0] list_mem [CAPACITY_DEF];
   int                        list_len = 0;

   list_outcome_type pending_outcomes [$];
   list_outcome_type arrived_outcome;
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;

   positional_list_store_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // apply one operation to the shadow list and return its outcome
   function automatic list_outcome_type apply_list_op(input logic [KIND_W-1:0] kind,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic signed [VALUE_W-1:0] val);
      list_outcome_type res;
      int               p;
      res = '0;
      res.status = plsu_pkg::ST_OK;
      p = int'(pos);
      case (kind)
         plsu_pkg::KIND_CLEAR: begin
            list_len = 0;
         end
         plsu_pkg::KIND_INSERT: begin
            if (p > list_len || list_len >= CAPACITY_DEF) begin
               res.status = plsu_pkg::ST_INVALID;
            end else begin
               for (int k = list_len; k > p; k--)
                  list_mem[k] = list_mem[k-1];
               list_mem[p] = val;
               list_len++;
            end
         end
         plsu_pkg::KIND_DELETE: begin
            if (p >= list_len) begin
               res.status = plsu_pkg::ST_INVALID;
            end else begin
               for (int k = p; k + 1 < list_len; k++)
                  list_mem[k] = list_mem[k+1];
               list_len--;
            end
         end
         plsu_pkg::KIND_SEARCH: begin
            res.status = plsu_pkg::ST_NOT_FOUND;
            for (int k = 0; k < list_len; k++) begin
               if (list_mem[k] == val) begin
                  res.status = plsu_pkg::ST_OK;
                  res.found_index = k[INDEX_W-1:0];
                  break;
               end
            end
         end
         plsu_pkg::KIND_READ: begin
            if (p >= list_len)
               res.status = plsu_pkg::ST_INVALID;
            else
               res.read_value = list_mem[p];
         end
         default: begin
            res.status = plsu_pkg::ST_INVALID;
         end
      endcase
      res.count = list_len[COUNT_W-1:0];
      return res;
   endfunction

   // hold one item on the request side until it is taken
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                            input logic signed [VALUE_W-1:0] val);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, val, pos};
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_outcomes.push_back(apply_list_op(kind, pos, val));
   endtask

   // many small values so searches find duplicates, some extremes, the rest random
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40)
         return $signed($urandom_range(16)) - 8;
      if (roll < 52) begin
         case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic send_random_item(input int mode);
      int                        roll;
      logic [KIND_W-1:0]         kind;
      logic [POS_W-1:0]          pos;
      logic signed [VALUE_W-1:0] val;
      roll = $urandom_range(99);
      val = pick_value();
      pos = '0;
      // noise: any kind, any position
      if ($urandom_range(99) < 10) begin
         kind = KIND_W'($urandom_range(7));
         pos  = POS_W'($urandom_range(63));
         val  = $urandom;
         send_item(kind, pos, val);
         return;
      end
      case (mode)
         MODE_FILL:  kind = (roll < 80) ? plsu_pkg::KIND_INSERT :
                            (roll < 90) ? plsu_pkg::KIND_SEARCH : plsu_pkg::KIND_READ;
         MODE_DRAIN: kind = (roll < 70) ? plsu_pkg::KIND_DELETE :
                            (roll < 85) ? plsu_pkg::KIND_SEARCH : plsu_pkg::KIND_READ;
         default: begin
            if (roll < 3)       kind = plsu_pkg::KIND_CLEAR;
            else if (roll < 33) kind = plsu_pkg::KIND_INSERT;
            else if (roll < 58) kind = plsu_pkg::KIND_DELETE;
            else if (roll < 80) kind = plsu_pkg::KIND_SEARCH;
            else                kind = plsu_pkg::KIND_READ;
         end
      endcase
      // keep positions mostly in range
      if (kind == plsu_pkg::KIND_INSERT)
         pos = POS_W'($urandom_range(list_len));
      else if (list_len > 0)
         pos = POS_W'($urandom_range(list_len - 1));
      if ($urandom_range(99) < 8)
         pos = POS_W'($urandom_range(63));
      if (kind == plsu_pkg::KIND_SEARCH && list_len > 0 && $urandom_range(99) < 60)
         val = list_mem[$urandom_range(list_len - 1)];
      send_item(kind, pos, val);
   endtask

   // operations on an empty list
   task automatic test_empty_list();
      send_item(plsu_pkg::KIND_READ, 6'd0, 32'sd5);
      send_item(plsu_pkg::KIND_DELETE, 6'd0, 32'sd0);
      send_item(plsu_pkg::KIND_SEARCH, 6'd0, 32'sd0);
      send_item(plsu_pkg::KIND_INSERT, 6'd1, 32'sd9);
      send_item(plsu_pkg::KIND_CLEAR, 6'd0, 32'sd0);
   endtask

   // extreme values and positions, shifting in both directions
   task automatic test_field_extremes();
      send_item(plsu_pkg::KIND_INSERT, 6'd0, 32'sh8000_0000);
      send_item(plsu_pkg::KIND_INSERT, 6'd1, 32'sh7FFF_FFFF);
      send_item(plsu_pkg::KIND_INSERT, 6'd0, 32'sd0);
      send_item(plsu_pkg::KIND_INSERT, 6'd4, 32'sd1);
      send_item(plsu_pkg::KIND_INSERT, 6'd63, -32'sd1);
      send_item(plsu_pkg::KIND_READ, 6'd0, 32'sd0);
      send_item(plsu_pkg::KIND_READ, 6'd1, 32'sd0);
      send_item(plsu_pkg::KIND_READ, 6'd2, 32'sd0);
      send_item(plsu_pkg::KIND_READ, 6'd63, 32'sd0);
      send_item(plsu_pkg::KIND_SEARCH, 6'd0, 32'sh7FFF_FFFF);
      send_item(plsu_pkg::KIND_SEARCH, 6'd63, 32'sh8000_0000);
      send_item(plsu_pkg::KIND_SEARCH, 6'd0, -32'sd1);
      send_item(plsu_pkg::KIND_DELETE, 6'd63, 32'sd0);
      send_item(plsu_pkg::KIND_DELETE, 6'd1, 32'sd0);
      send_item(plsu_pkg::KIND_READ, 6'd1, 32'sd0);
      send_item(plsu_pkg::KIND_DELETE, 6'd2, 32'sd0);
   endtask

   // kinds with no operation behind them, then a clear
   task automatic test_unused_kinds();
      send_item(3'd5, 6'd0, 32'sd0);
      send_item(3'd6, 6'd63, -32'sd1);
      send_item(3'd7, 6'd63, -32'sd1);
      send_item(plsu_pkg::KIND_CLEAR, 6'd63, -32'sd1);
   endtask

   // bursts of fill, drain and mixed traffic under one idling setting
   task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
      int mode;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      mode = MODE_FILL;
      for (int i = 0; i < items; i++) begin
         if (i % 48 == 0)
            mode = (i % 144 == 0) ? MODE_FILL : int'($urandom_range(MODE_MIXED));
         send_random_item(mode);
      end
   endtask

   // stall the response side at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // compare each response item with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response item with no prediction waiting");
            mismatch_count++;
         end else begin
            arrived_outcome = pending_outcomes.pop_front();
            if (rsp_tuser !== arrived_outcome.status) begin
               $error("status: expected %0d, got %0d", arrived_outcome.status, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[4:0] !== arrived_outcome.found_index) begin
               $error("found_index: expected %0d, got %0d", arrived_outcome.found_index,
                      rsp_tdata[4:0]);
               mismatch_count++;
            end
            if (rsp_tdata[36:5] !== arrived_outcome.read_value) begin
               $error("read_value: expected %0d, got %0d", arrived_outcome.read_value,
                      $signed(rsp_tdata[36:5]));
               mismatch_count++;
            end
            if (rsp_tdata[42:37] !== arrived_outcome.count) begin
               $error("count: expected %0d, got %0d", arrived_outcome.count,
                      rsp_tdata[42:37]);
               mismatch_count++;
            end
         end
      end
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("positional_list_store_unit: mismatch");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < CAPACITY_DEF; k++)
         list_mem[k] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_field_extremes();
      test_unused_kinds();
      test_random_traffic(232, 0, 0);
      test_random_traffic(232, 83, 0);
      test_random_traffic(232, 0, 83);
      test_random_traffic(232, 29, 29);

      // drop valid and wait for the last responses
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("positional_list_store_unit: match");
      else
         $display("positional_list_store_unit: mismatch");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/plsu_pkg.sv
sv/plsu_cell.sv
sv/plsu_resolve.sv
sv/positional_list_store_unit.sv
test/tb.sv
